// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // Default table depth
    localparam int NUM_SLOTS_DEF = 128;

    // Field widths
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int LIVE_W    = 8;
    localparam int STATE_W   = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATE_W-1:0]  slot_st_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes
    localparam op_t OP_TICK   = 3'd0;
    localparam op_t OP_CREATE = 3'd1;
    localparam op_t OP_EXIT   = 3'd2;
    localparam op_t OP_JOIN   = 3'd3;
    localparam op_t OP_BLOCK  = 3'd4;
    localparam op_t OP_WAKE   = 3'd5;

    // Slot states
    localparam slot_st_t ST_EMPTY   = 3'd0;
    localparam slot_st_t ST_READY   = 3'd1;
    localparam slot_st_t ST_RUNNING = 3'd2;
    localparam slot_st_t ST_BLOCKED = 3'd3;
    localparam slot_st_t ST_EXITED  = 3'd4;

    // Result status codes
    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_NO_READY  = 3'd1;
    localparam status_t STATUS_FULL      = 3'd2;
    localparam status_t STATUS_NO_THREAD = 3'd3;
    localparam status_t STATUS_NOT_EXIT  = 3'd4;

    // Write address select
    typedef enum logic [1:0] {
        WR_CUR,
        WR_HIT,
        WR_TGT
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     clear_wr;
        logic     scan_start;
        logic     scan_from_zero;
        slot_st_t scan_code;
        logic     rd_target;
        logic     wr_en;
        wr_sel_t  wr_sel;
        slot_st_t wr_data;
        logic     live_inc;
        logic     live_dec;
        logic     set_cur;
        logic     set_new;
        logic     load_out;
        status_t  out_status;
    } rrts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic     clear_last;
        logic     scan_hit;
        logic     scan_miss;
        logic     cur_running;
        logic     tgt_ok;
        slot_st_t rd_state;
        op_t      op;
    } rrts_sts_t;

endpackage

`default_nettype wire

// File: rtl/rrts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rrts_datapath #(
    parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rrts_pkg::OP_W-1:0]     operation,
    input  wire logic [rrts_pkg::SLOT_W-1:0]   slot,
    input  wire rrts_pkg::rrts_cmd_t           cmd,
    output rrts_pkg::rrts_sts_t                sts,
    output logic [rrts_pkg::STATUS_W-1:0]      status,
    output logic [rrts_pkg::SLOT_W-1:0]        running_slot,
    output logic [rrts_pkg::SLOT_W-1:0]        new_slot,
    output logic [rrts_pkg::LIVE_W-1:0]        live_threads
);

    localparam int IW = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = ((IW > rrts_pkg::SLOT_W) ? IW : rrts_pkg::SLOT_W) + 1;
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_SLOTS - 1);
    localparam logic [LW-1:0] LEFT_FULL = LW'(NUM_SLOTS);

    // Thread table
    rrts_pkg::slot_st_t mem [NUM_SLOTS];

    rrts_pkg::op_t           op_reg;
    logic [rrts_pkg::SLOT_W-1:0] slot_reg;
    logic [IW-1:0]           new_reg;

    logic [IW-1:0]           cur_reg, cur_next;
    rrts_pkg::slot_st_t      cur_st_reg, cur_st_next;
    logic [LW-1:0]           live_reg, live_next;

    // Scan engine
    logic [IW-1:0]           ptr_reg, ptr_next;
    logic [LW-1:0]           left_reg;
    logic                    issue_reg;
    logic                    scan_live_reg;
    rrts_pkg::slot_st_t      code_reg;
    logic                    rd_vld_reg;
    logic                    rd_last_reg;
    logic [IW-1:0]           rd_tag_reg;
    rrts_pkg::slot_st_t      rd_data_reg;

    logic [CW-1:0]           tgt_ext;
    logic [IW-1:0]           tgt_idx;
    logic                    tgt_ok;
    logic                    hit;
    logic                    miss;
    logic                    we;
    logic [IW-1:0]           waddr;
    rrts_pkg::slot_st_t      wdata;
    logic                    rd_en;
    logic [IW-1:0]           raddr;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
        wrap_inc = (v == LAST_IDX) ? '0 : v + IW'(1);
    endfunction

    // Target decode
    assign tgt_ext = CW'(slot_reg);
    assign tgt_ok  = tgt_ext < CW'(NUM_SLOTS);
    assign tgt_idx = tgt_ext[IW-1:0];

    // Scan compare on the registered read beat
    assign hit  = scan_live_reg && rd_vld_reg && (rd_data_reg == code_reg);
    assign miss = scan_live_reg && rd_vld_reg && rd_last_reg && !hit;

    // Write port select
    always_comb
    begin
        case (cmd.wr_sel)
            rrts_pkg::WR_CUR: waddr = cur_reg;
            rrts_pkg::WR_HIT: waddr = rd_tag_reg;
            rrts_pkg::WR_TGT: waddr = tgt_idx;
            default:          waddr = cur_reg;
        endcase
        wdata = cmd.wr_data;
        if (cmd.clear_wr)
        begin
            waddr = ptr_reg;
            wdata = (ptr_reg == '0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_EMPTY;
        end
        we = cmd.wr_en || cmd.clear_wr;
    end

    // Read port select
    assign rd_en = issue_reg || cmd.rd_target;
    assign raddr = issue_reg ? ptr_reg : tgt_idx;

    // Table memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rd_data_reg <= mem[raddr];
    end

    // Current slot, its mirrored state and the live count
    always_comb
    begin
        cur_next    = cur_reg;
        cur_st_next = cur_st_reg;
        if (cmd.set_cur)
        begin
            cur_next    = rd_tag_reg;
            cur_st_next = rrts_pkg::ST_RUNNING;
        end
        else if (we && (waddr == cur_reg))
            cur_st_next = wdata;

        live_next = live_reg;
        if (cmd.live_inc)
            live_next = live_reg + LW'(1);
        else if (cmd.live_dec && (live_reg != '0))
            live_next = live_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            cur_st_reg <= rrts_pkg::ST_RUNNING;
            live_reg   <= LW'(1);
        end
        else
        begin
            cur_reg    <= cur_next;
            cur_st_reg <= cur_st_next;
            live_reg   <= live_next;
        end
    end

    // Scan pointer: clearing sweep, round-robin or lowest-first search
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_start)
            ptr_next = cmd.scan_from_zero ? '0 : wrap_inc(cur_reg);
        else if (issue_reg || cmd.clear_wr)
            ptr_next = wrap_inc(ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            left_reg      <= '0;
            issue_reg     <= 1'b0;
            scan_live_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= issue_reg;
            rd_last_reg <= issue_reg && (left_reg == LW'(1));
            if (cmd.scan_start)
            begin
                left_reg      <= LEFT_FULL;
                issue_reg     <= 1'b1;
                scan_live_reg <= 1'b1;
            end
            else
            begin
                if (issue_reg)
                begin
                    left_reg <= left_reg - LW'(1);
                    if (left_reg == LW'(1))
                        issue_reg <= 1'b0;
                end
                if (hit)
                begin
                    issue_reg     <= 1'b0;
                    scan_live_reg <= 1'b0;
                end
                else if (miss)
                    scan_live_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_tag_reg <= ptr_reg;
        if (cmd.scan_start)
            code_reg <= cmd.scan_code;
        if (cmd.accept)
        begin
            op_reg   <= operation;
            slot_reg <= slot;
            new_reg  <= '0;
        end
        else if (cmd.set_new)
            new_reg <= rd_tag_reg;
        if (cmd.load_out)
        begin
            status       <= cmd.out_status;
            running_slot <= rrts_pkg::SLOT_W'(cur_reg);
            new_slot     <= rrts_pkg::SLOT_W'(new_reg);
            live_threads <= rrts_pkg::LIVE_W'(live_reg);
        end
    end

    // Status to controller
    always_comb
    begin
        sts.clear_last  = (ptr_reg == LAST_IDX);
        sts.scan_hit    = hit;
        sts.scan_miss   = miss;
        sts.cur_running = (cur_st_reg == rrts_pkg::ST_RUNNING);
        sts.tgt_ok      = tgt_ok;
        sts.rd_state    = rd_data_reg;
        sts.op          = op_reg;
    end

endmodule

`default_nettype wire

// File: rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output rrts_pkg::rrts_cmd_t       cmd,
    input  wire rrts_pkg::rrts_sts_t  sts
);

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        DISPATCH,
        FIND,
        DEMOTE,
        RSCAN,
        TGT_CHK,
        DONE
    } state_t;

    state_t            state_reg, state_next;
    rrts_pkg::status_t status_reg, status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_free;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencing and commands
    always_comb
    begin
        cmd           = '0;
        cmd.wr_sel    = rrts_pkg::WR_CUR;
        state_next    = state_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                    state_next = IDLE;
            end

            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = DISPATCH;
                end
            end

            DISPATCH:
            begin
                status_next = rrts_pkg::STATUS_OK;
                case (sts.op)
                    rrts_pkg::OP_TICK:
                        state_next = DEMOTE;
                    rrts_pkg::OP_CREATE:
                    begin
                        cmd.scan_start     = 1'b1;
                        cmd.scan_from_zero = 1'b1;
                        cmd.scan_code      = rrts_pkg::ST_EMPTY;
                        state_next         = FIND;
                    end
                    rrts_pkg::OP_EXIT, rrts_pkg::OP_BLOCK:
                    begin
                        if (!sts.cur_running)
                        begin
                            status_next = rrts_pkg::STATUS_NO_THREAD;
                            state_next  = DONE;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = rrts_pkg::WR_CUR;
                            cmd.wr_data  = (sts.op == rrts_pkg::OP_EXIT) ?
                                           rrts_pkg::ST_EXITED : rrts_pkg::ST_BLOCKED;
                            cmd.live_dec = (sts.op == rrts_pkg::OP_EXIT);
                            state_next   = DEMOTE;
                        end
                    end
                    rrts_pkg::OP_JOIN, rrts_pkg::OP_WAKE:
                    begin
                        if (!sts.tgt_ok)
                        begin
                            status_next = rrts_pkg::STATUS_NO_THREAD;
                            state_next  = DONE;
                        end
                        else
                        begin
                            cmd.rd_target = 1'b1;
                            state_next    = TGT_CHK;
                        end
                    end
                    default:
                        state_next = DONE;
                endcase
            end

            // Lowest empty slot for create
            FIND:
            begin
                if (sts.scan_hit)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = rrts_pkg::WR_HIT;
                    cmd.wr_data  = rrts_pkg::ST_READY;
                    cmd.live_inc = 1'b1;
                    cmd.set_new  = 1'b1;
                    state_next   = DEMOTE;
                end
                else if (sts.scan_miss)
                begin
                    status_next = rrts_pkg::STATUS_FULL;
                    state_next  = DONE;
                end
            end

            // Running thread yields, then round-robin search starts
            DEMOTE:
            begin
                if (sts.cur_running)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = rrts_pkg::WR_CUR;
                    cmd.wr_data = rrts_pkg::ST_READY;
                end
                cmd.scan_start = 1'b1;
                cmd.scan_code  = rrts_pkg::ST_READY;
                state_next     = RSCAN;
            end

            RSCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = rrts_pkg::WR_HIT;
                    cmd.wr_data = rrts_pkg::ST_RUNNING;
                    cmd.set_cur = 1'b1;
                    status_next = rrts_pkg::STATUS_OK;
                    state_next  = DONE;
                end
                else if (sts.scan_miss)
                begin
                    status_next = rrts_pkg::STATUS_NO_READY;
                    state_next  = DONE;
                end
            end

            // Join or wake on the target slot
            TGT_CHK:
            begin
                cmd.wr_sel = rrts_pkg::WR_TGT;
                if (sts.op == rrts_pkg::OP_JOIN)
                begin
                    if (sts.rd_state == rrts_pkg::ST_EMPTY)
                        status_next = rrts_pkg::STATUS_NO_THREAD;
                    else if (sts.rd_state != rrts_pkg::ST_EXITED)
                        status_next = rrts_pkg::STATUS_NOT_EXIT;
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = rrts_pkg::ST_EMPTY;
                    end
                end
                else
                begin
                    if (sts.rd_state != rrts_pkg::ST_BLOCKED)
                        status_next = rrts_pkg::STATUS_NO_THREAD;
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = rrts_pkg::ST_READY;
                    end
                end
                state_next = DONE;
            end

            // Hand the result to the output register once it is free
            DONE:
            begin
                cmd.out_status = status_reg;
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end

            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CLEAR;
            status_reg   <= rrts_pkg::STATUS_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/round_robin_thread_scheduler.sv
// One item at a time: the next beat is taken in the cycle after the result is registered,
// and the time per item is set by the one-slot-per-cycle scan through the table's read port
// for tick, create and accepted exit and block, and by any wait of the result on m_tready.
// Reset (rst_n, asynchronous) is followed by a clearing pass over all NUM_SLOTS slots;
// s_tready stays low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler #(
    parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // operation [2:0], slot [9:3], zero [15:10]
    input  wire logic [rrts_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status [2:0], running_slot [9:3], new_slot [16:10], live_threads [24:17], zero [31:25]
    output logic [rrts_pkg::M_TDATA_W-1:0]        m_tdata
);

    rrts_pkg::rrts_cmd_t               cmd;
    rrts_pkg::rrts_sts_t               sts;
    logic [rrts_pkg::STATUS_W-1:0]     status;
    logic [rrts_pkg::SLOT_W-1:0]       running_slot;
    logic [rrts_pkg::SLOT_W-1:0]       new_slot;
    logic [rrts_pkg::LIVE_W-1:0]       live_threads;

    // Sequencer
    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Thread table, scan engine and result register
    rrts_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (s_tdata[2:0]),
        .slot         (s_tdata[9:3]),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .running_slot (running_slot),
        .new_slot     (new_slot),
        .live_threads (live_threads)
    );

    // Result beat packing
    assign m_tdata = {7'd0, live_threads, new_slot, running_slot, status};

endmodule

`default_nettype wire

// File: verif/round_robin_thread_scheduler_test.sv
`timescale 1ns / 1ps

module round_robin_thread_scheduler_test;

    localparam int          NUM_SLOTS   = rrts_pkg::NUM_SLOTS_DEF;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          SETTLE      = 2 * NUM_SLOTS + 10;

    // Unassigned operation codes: the block must treat them as no-ops
    localparam rrts_pkg::op_t OP_RSVD6 = 3'd6;
    localparam rrts_pkg::op_t OP_RSVD7 = 3'd7;

    // Mixes for the random churn
    localparam int MIX_GROW    = 0;
    localparam int MIX_SHRINK  = 1;
    localparam int MIX_BALANCE = 2;

    typedef struct packed {
        rrts_pkg::status_t status;
        logic [6:0]        running;
        logic [6:0]        new_slot;
        logic [7:0]        live;
    } sched_reply_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rrts_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rrts_pkg::M_TDATA_W-1:0]  m_tdata;

    // Shadow thread table
    rrts_pkg::slot_st_t thread_st [NUM_SLOTS];
    int unsigned  cur_slot;
    int unsigned  live_cnt;

    sched_reply_t sched_replies_q[$];

    int unsigned  cycle_cnt    = 0;
    int unsigned  mismatch_cnt = 0;
    int unsigned  replies_seen = 0;
    int unsigned  ops_sent [8];
    int unsigned  status_seen [8];
    int unsigned  peak_live    = 1;
    bit           tx_quiet     = 1'b0;
    bit           rx_quiet     = 1'b0;

    round_robin_thread_scheduler #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_cnt, sched_replies_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want_v);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want_v);
        mismatch_cnt++;
    endtask

    // Shadow table after reset
    function automatic void reset_thread_table();
        foreach (thread_st[i])
            thread_st[i] = rrts_pkg::ST_EMPTY;
        thread_st[0] = rrts_pkg::ST_RUNNING;
        cur_slot     = 0;
        live_cnt     = 1;
    endfunction

    // Yield the current thread and pick the next ready one, current slot tried last
    function automatic rrts_pkg::status_t pick_next_thread();
        int unsigned idx;
        if (thread_st[cur_slot] == rrts_pkg::ST_RUNNING)
            thread_st[cur_slot] = rrts_pkg::ST_READY;
        for (int i = 1; i <= NUM_SLOTS; i++)
        begin
            idx = (cur_slot + i) % NUM_SLOTS;
            if (thread_st[idx] == rrts_pkg::ST_READY)
            begin
                cur_slot       = idx;
                thread_st[idx] = rrts_pkg::ST_RUNNING;
                return rrts_pkg::STATUS_OK;
            end
        end
        return rrts_pkg::STATUS_NO_READY;
    endfunction

    // Apply one operation to the shadow table and form the reply it should give
    function automatic sched_reply_t apply_sched_op(rrts_pkg::op_t op, logic [6:0] tgt);
        sched_reply_t r;
        int unsigned  free_idx;
        r.status   = rrts_pkg::STATUS_OK;
        r.new_slot = '0;
        case (op)
            rrts_pkg::OP_TICK:
                r.status = pick_next_thread();
            rrts_pkg::OP_CREATE:
            begin
                free_idx = NUM_SLOTS;
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (thread_st[i] == rrts_pkg::ST_EMPTY)
                        free_idx = i;
                if (free_idx == NUM_SLOTS)
                    r.status = rrts_pkg::STATUS_FULL;
                else
                begin
                    thread_st[free_idx] = rrts_pkg::ST_READY;
                    live_cnt++;
                    r.new_slot = 7'(free_idx);
                    void'(pick_next_thread());
                end
            end
            rrts_pkg::OP_EXIT:
                if (thread_st[cur_slot] != rrts_pkg::ST_RUNNING)
                    r.status = rrts_pkg::STATUS_NO_THREAD;
                else
                begin
                    thread_st[cur_slot] = rrts_pkg::ST_EXITED;
                    if (live_cnt > 0)
                        live_cnt--;
                    r.status = pick_next_thread();
                end
            rrts_pkg::OP_JOIN:
                if (thread_st[tgt] == rrts_pkg::ST_EMPTY)
                    r.status = rrts_pkg::STATUS_NO_THREAD;
                else if (thread_st[tgt] != rrts_pkg::ST_EXITED)
                    r.status = rrts_pkg::STATUS_NOT_EXIT;
                else
                    thread_st[tgt] = rrts_pkg::ST_EMPTY;
            rrts_pkg::OP_BLOCK:
                if (thread_st[cur_slot] != rrts_pkg::ST_RUNNING)
                    r.status = rrts_pkg::STATUS_NO_THREAD;
                else
                begin
                    thread_st[cur_slot] = rrts_pkg::ST_BLOCKED;
                    r.status = pick_next_thread();
                end
            rrts_pkg::OP_WAKE:
                if (thread_st[tgt] != rrts_pkg::ST_BLOCKED)
                    r.status = rrts_pkg::STATUS_NO_THREAD;
                else
                    thread_st[tgt] = rrts_pkg::ST_READY;
            default: ;
        endcase
        r.running = 7'(cur_slot);
        r.live    = 8'(live_cnt);
        return r;
    endfunction

    function automatic int count_in_state(rrts_pkg::slot_st_t st);
        int n;
        n = 0;
        foreach (thread_st[i])
            if (thread_st[i] == st)
                n++;
        return n;
    endfunction

    // Mostly a slot in the given state, sometimes any slot
    function automatic logic [6:0] pick_target(rrts_pkg::slot_st_t st);
        int unsigned hits[$];
        foreach (thread_st[i])
            if (thread_st[i] == st)
                hits.push_back(i);
        if (hits.size() == 0 || $urandom_range(0, 4) == 0)
            return 7'($urandom_range(0, 127));
        return 7'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send one operation beat and log what it should produce
    task automatic issue_sched_op(rrts_pkg::op_t op, logic [6:0] tgt);
        int gap;
        gap = tx_quiet ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rrts_pkg::S_TDATA_W - 10){1'b0}}, tgt, op};
        do
            @(posedge clk);
        while (!s_tready);
        sched_replies_q.push_back(apply_sched_op(op, tgt));
        ops_sent[op]++;
        if (live_cnt > peak_live)
            peak_live = live_cnt;
    endtask

    // Output stalls
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 2) == 0)
                    hold = idle_len();
            end
        end
    end

    // Compare each result beat with the oldest pending reply
    always @(posedge clk)
    begin : result_check
        sched_reply_t want;
        logic [rrts_pkg::M_TDATA_W-1:0] beat;
        if (m_tvalid && m_tready)
        begin
            beat = m_tdata;
            if (sched_replies_q.size() == 0)
                flag_mismatch("unsolicited result beat", beat, 0);
            else
            begin
                want = sched_replies_q.pop_front();
                replies_seen++;
                status_seen[beat[2:0]]++;
                if (beat[2:0] != want.status)
                    flag_mismatch("status", beat[2:0], want.status);
                if (beat[9:3] != want.running)
                    flag_mismatch("running_slot", beat[9:3], want.running);
                if (beat[16:10] != want.new_slot)
                    flag_mismatch("new_slot", beat[16:10], want.new_slot);
                if (beat[24:17] != want.live)
                    flag_mismatch("live_threads", beat[24:17], want.live);
                if (beat[rrts_pkg::M_TDATA_W-1:25] != '0)
                    flag_mismatch("pad bits", beat[rrts_pkg::M_TDATA_W-1:25], 0);
            end
        end
    end

    // Every operation and the corner states of a table with few threads
    task automatic test_directed();
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);      // lone thread yields to itself
        issue_sched_op(OP_RSVD6, 7'h55);
        issue_sched_op(OP_RSVD7, 7'h2a);
        issue_sched_op(rrts_pkg::OP_CREATE, 7'd0);
        issue_sched_op(rrts_pkg::OP_CREATE, 7'h7f);
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);      // wraps round to slot 0
        issue_sched_op(rrts_pkg::OP_BLOCK, 7'd0);
        issue_sched_op(rrts_pkg::OP_WAKE, 7'd0);
        issue_sched_op(rrts_pkg::OP_WAKE, 7'd0);      // no longer blocked
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd0);      // live thread, not exited
        issue_sched_op(rrts_pkg::OP_EXIT, 7'd0);
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd1);
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd1);      // now empty
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd127);
        issue_sched_op(rrts_pkg::OP_WAKE, 7'd127);
        issue_sched_op(rrts_pkg::OP_EXIT, 7'd0);
        issue_sched_op(rrts_pkg::OP_BLOCK, 7'd0);     // nothing else ready
        issue_sched_op(rrts_pkg::OP_BLOCK, 7'd0);     // current not running
        issue_sched_op(rrts_pkg::OP_EXIT, 7'd0);
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);
        issue_sched_op(rrts_pkg::OP_WAKE, 7'd0);
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);      // ready current picked last
        issue_sched_op(rrts_pkg::OP_EXIT, 7'd0);      // last thread gone
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd0);      // join the slot still pointed at
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);
        issue_sched_op(rrts_pkg::OP_CREATE, 7'd0);
        issue_sched_op(rrts_pkg::OP_JOIN, 7'd2);
    endtask

    // Fill the table, overflow it, spin the round robin, block and wake threads, then drain it all
    task automatic test_fill_and_drain();
        while (count_in_state(rrts_pkg::ST_EMPTY) > 0)
            issue_sched_op(rrts_pkg::OP_CREATE, 7'($urandom_range(0, 127)));
        issue_sched_op(rrts_pkg::OP_CREATE, 7'($urandom_range(0, 127)));
        repeat (NUM_SLOTS + 8)
            issue_sched_op(rrts_pkg::OP_TICK, 7'($urandom_range(0, 127)));
        repeat (6)
            issue_sched_op(rrts_pkg::OP_BLOCK, 7'($urandom_range(0, 127)));
        while (count_in_state(rrts_pkg::ST_BLOCKED) > 0)
            issue_sched_op(rrts_pkg::OP_WAKE, pick_target(rrts_pkg::ST_BLOCKED));
        while (live_cnt > 0)
        begin
            if (thread_st[cur_slot] == rrts_pkg::ST_RUNNING)
                issue_sched_op(rrts_pkg::OP_EXIT, 7'($urandom_range(0, 127)));
            else
                issue_sched_op(rrts_pkg::OP_TICK, 7'($urandom_range(0, 127)));
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            if (thread_st[i] == rrts_pkg::ST_EXITED)
                issue_sched_op(rrts_pkg::OP_JOIN, 7'(i));
        issue_sched_op(rrts_pkg::OP_TICK, 7'd0);
        issue_sched_op(rrts_pkg::OP_EXIT, 7'd0);
        issue_sched_op(rrts_pkg::OP_CREATE, 7'd0);
    endtask

    // Random operations weighted by mix, with join and wake aimed mostly at valid targets
    task automatic test_random_churn(int n, int mix);
        int unsigned r;
        int          w_create, w_tick, w_exit, w_join, w_block, w_wake;
        case (mix)
            MIX_GROW:   begin w_create = 35; w_tick = 25; w_exit = 8;  w_join = 10;
                              w_block = 8;  w_wake = 10; end
            MIX_SHRINK: begin w_create = 8;  w_tick = 20; w_exit = 25; w_join = 25;
                              w_block = 8;  w_wake = 10; end
            default:    begin w_create = 18; w_tick = 24; w_exit = 15; w_join = 15;
                              w_block = 10; w_wake = 14; end
        endcase
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < w_create)
                issue_sched_op(rrts_pkg::OP_CREATE, 7'($urandom_range(0, 127)));
            else if (r < w_create + w_tick)
                issue_sched_op(rrts_pkg::OP_TICK, 7'($urandom_range(0, 127)));
            else if (r < w_create + w_tick + w_exit)
                issue_sched_op(rrts_pkg::OP_EXIT, 7'($urandom_range(0, 127)));
            else if (r < w_create + w_tick + w_exit + w_join)
                issue_sched_op(rrts_pkg::OP_JOIN, pick_target(rrts_pkg::ST_EXITED));
            else if (r < w_create + w_tick + w_exit + w_join + w_block)
                issue_sched_op(rrts_pkg::OP_BLOCK, 7'($urandom_range(0, 127)));
            else if (r < w_create + w_tick + w_exit + w_join + w_block + w_wake)
                issue_sched_op(rrts_pkg::OP_WAKE, pick_target(rrts_pkg::ST_BLOCKED));
            else
                issue_sched_op($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7,
                               7'($urandom_range(0, 127)));
        end
    endtask

    // Same churn with neither side idling
    task automatic test_back_to_back(int n);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        test_random_churn(n, MIX_BALANCE);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic wait_for_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sched_replies_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        reset_thread_table();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_churn(350, MIX_GROW);
        test_random_churn(350, MIX_SHRINK);
        test_back_to_back(200);
        test_random_churn(400, MIX_BALANCE);
        wait_for_replies();

        $display("Sent %0d ops: tick %0d create %0d exit %0d join %0d block %0d wake %0d",
                 replies_seen, ops_sent[rrts_pkg::OP_TICK], ops_sent[rrts_pkg::OP_CREATE],
                 ops_sent[rrts_pkg::OP_EXIT], ops_sent[rrts_pkg::OP_JOIN],
                 ops_sent[rrts_pkg::OP_BLOCK], ops_sent[rrts_pkg::OP_WAKE]);
        $display("spare %0d; peak live %0d; status ok %0d no-ready %0d full %0d",
                 ops_sent[OP_RSVD6] + ops_sent[OP_RSVD7], peak_live,
                 status_seen[rrts_pkg::STATUS_OK], status_seen[rrts_pkg::STATUS_NO_READY],
                 status_seen[rrts_pkg::STATUS_FULL]);
        $display("no-thread %0d not-exited %0d",
                 status_seen[rrts_pkg::STATUS_NO_THREAD],
                 status_seen[rrts_pkg::STATUS_NOT_EXIT]);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
